/* rtl/assert_macros.svh */
// Assertion macros shared by the table modules.
// Included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// check an implication at each clock edge outside reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// check a next-cycle implication outside reset
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* rtl/plc_pkg.sv */
// Package for the pinned LRU cache table: sizes, codes and command types.
// No dependencies.
`timescale 1ns / 1ps
package plc_pkg;
    localparam int ENTRIES = 16;
    localparam int REF_MAX = 255;
    localparam int SW = $clog2(ENTRIES);
    localparam int CW = $clog2(REF_MAX + 1);
    localparam int NW = $clog2(ENTRIES + 1);

    localparam logic [1:0] OP_INSERT  = 2'd0;
    localparam logic [1:0] OP_LOOKUP  = 2'd1;
    localparam logic [1:0] OP_RELEASE = 2'd2;
    localparam logic [1:0] OP_ERASE   = 2'd3;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_MISS  = 3'd1;
    localparam logic [2:0] ST_FULL  = 3'd2;
    localparam logic [2:0] ST_LIMIT = 3'd3;
    localparam logic [2:0] ST_BAD   = 3'd4;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] key;
        logic [31:0] value;
        logic [3:0]  slot;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  result_slot;
        logic [31:0] result_value;
    } t_rsp;

    // controller to datapath
    typedef struct packed {
        logic latch;    // capture request
        logic search;   // register key match and free search
        logic evict;    // displace oldest unpinned entry
        logic execute;  // perform the operation
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic need_evict;
        t_rsp rsp;
    } t_sts;
endpackage

/* rtl/plc_if.sv */
// Valid/ready channel interfaces for requests and responses.
// Depends on plc_pkg.
`timescale 1ns / 1ps
interface plc_req_if;
    import plc_pkg::*;
    logic valid;
    logic ready;
    logic [1:0]  op;
    logic [31:0] key;
    logic [31:0] value;
    logic [3:0]  slot;
    modport source (output valid, op, key, value, slot, input ready);
    modport sink (input valid, op, key, value, slot, output ready);
endinterface

interface plc_rsp_if;
    logic valid;
    logic ready;
    logic [2:0]  status;
    logic [3:0]  result_slot;
    logic [31:0] result_value;
    modport source (output valid, status, result_slot, result_value, input ready);
    modport sink (input valid, status, result_slot, result_value, output ready);
endinterface

/* rtl/pinned_lru_cache_table.sv */
// Top level of the pinned LRU cache table: controller plus datapath.
// Depends on plc_pkg, plc_if, plc_ctrl and plc_datapath.
//
// channel | dir | payload
// req     | in  | op, key, value, slot
// rsp     | out | status, result_slot, result_value
// cfg     | in  | capacity (write enable + data)
//
// Lookup, release and erase pass through search, execute and output; insert first evicts as needed.
// Eviction walks the recency list head, one entry per cycle.
// A result waits in the output register; the next request is taken meanwhile.
// Reset clears counts, live bits, list length and usage; capacity returns to 16.
`timescale 1ns / 1ps
module pinned_lru_cache_table (
    input  logic       i_clk,
    input  logic       i_rst_n,
    plc_req_if.sink    i_req,
    plc_rsp_if.source  o_rsp,
    input  logic       i_cfg_we,
    input  logic [4:0] i_cfg_data
);
    import plc_pkg::*;

    logic [4:0] r_capacity;
    t_req       req;
    t_cmd       cmd;
    t_sts       sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= 5'd16;
        end else if (i_cfg_we) begin
            r_capacity <= i_cfg_data;
        end
    end

    assign req.op    = i_req.op;
    assign req.key   = i_req.key;
    assign req.value = i_req.value;
    assign req.slot  = i_req.slot;

    plc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .i_op        (i_req.op),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready)
    );

    plc_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req),
        .i_capacity (r_capacity),
        .i_cmd      (cmd),
        .o_sts      (sts)
    );

    assign o_rsp.status       = sts.rsp.status;
    assign o_rsp.result_slot  = sts.rsp.result_slot;
    assign o_rsp.result_value = sts.rsp.result_value;
endmodule

/* rtl/plc_datapath.sv */
// Datapath: slot stores, counts, recency list, search and update.
// Depends on plc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module plc_datapath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  plc_pkg::t_req  i_req,
    input  logic [4:0]     i_capacity,
    input  plc_pkg::t_cmd  i_cmd,
    output plc_pkg::t_sts  o_sts
);
    import plc_pkg::*;

    logic [31:0]   r_key   [ENTRIES];
    logic [31:0]   r_val   [ENTRIES];
    logic [CW-1:0] r_cnt   [ENTRIES];
    logic [ENTRIES-1:0] r_live;
    logic [SW-1:0] r_ord   [ENTRIES];
    logic [NW-1:0] r_olen, r_usage;
    t_req          r_req;

    logic          r_hit;
    logic [SW-1:0] r_hslot;
    logic          r_free_ok;
    logic [SW-1:0] r_fslot;
    t_rsp          r_rsp;

    logic [ENTRIES-1:0] match;
    logic          hit;
    logic [SW-1:0] hslot;
    logic          free_ok;
    logic [SW-1:0] fslot;
    logic [NW-1:0] eff;

    always_comb begin
        hit = 1'b0;
        hslot = '0;
        free_ok = 1'b0;
        fslot = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            match[i] = r_live[i] && (r_cnt[i] != '0) && (r_key[i] == r_req.key);
            if (match[i]) begin
                hit = 1'b1;
                hslot = SW'(i);
            end
            if (r_cnt[i] == '0) begin
                free_ok = 1'b1;
                fslot = SW'(i);
            end
        end
        if (i_capacity > 5'(ENTRIES)) begin
            eff = NW'(ENTRIES);
        end else begin
            eff = NW'(i_capacity);
        end
    end

    assign o_sts.need_evict = (r_usage >= eff) && (r_olen != '0);
    assign o_sts.rsp = r_rsp;

    // position of a slot in the recency list
    function automatic logic [SW:0] ord_pos(input logic [SW-1:0] s,
                                            input logic [SW-1:0] ord [ENTRIES],
                                            input logic [NW-1:0] len);
        logic [SW:0] p;
        p = {1'b1, {SW{1'b0}}};
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (NW'(i) < len && ord[i] == s) begin
                p = (SW + 1)'(i);
            end
        end
        return p;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live  <= '0;
            r_olen  <= '0;
            r_usage <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_cnt[i] <= '0;
            end
        end else begin
            if (i_cmd.latch) begin
                r_req <= i_req;
            end
            if (i_cmd.search) begin
                r_hit     <= hit;
                r_hslot   <= hslot;
                r_free_ok <= free_ok && (r_usage < eff);
                r_fslot   <= fslot;
            end
            if (i_cmd.evict) begin
                // displace the head: unlink, clear, drop one count
                for (int j = 0; j < ENTRIES - 1; j++) begin
                    r_ord[j] <= r_ord[j + 1];
                end
                r_olen <= r_olen - 1'b1;
                r_live[r_ord[0]] <= 1'b0;
                if (r_cnt[r_ord[0]] != '0) begin
                    r_cnt[r_ord[0]] <= r_cnt[r_ord[0]] - 1'b1;
                    if (r_cnt[r_ord[0]] == CW'(1)) begin
                        r_usage <= r_usage - 1'b1;
                    end
                end
            end
            if (i_cmd.execute) begin
                r_rsp <= '0;
                case (r_req.op)
                    OP_INSERT: begin
                        if (!r_free_ok) begin
                            r_rsp.status <= ST_FULL;
                        end else begin
                            logic [SW:0] p;
                            logic [SW-1:0] ord_n [ENTRIES];
                            logic [NW-1:0] len_n;
                            logic [NW-1:0] use_n;
                            ord_n = r_ord;
                            len_n = r_olen;
                            use_n = r_usage + 1'b1;
                            r_key[r_fslot] <= r_req.key;
                            r_val[r_fslot] <= r_req.value;
                            r_rsp.result_slot <= r_fslot;
                            if (r_hit) begin
                                p = ord_pos(r_hslot, ord_n, len_n);
                                if (!p[SW]) begin
                                    for (int j = 0; j < ENTRIES - 1; j++) begin
                                        if (j >= int'(p[SW-1:0])) begin
                                            ord_n[j] = ord_n[j + 1];
                                        end
                                    end
                                    len_n = len_n - 1'b1;
                                end
                            end
                            if (len_n < NW'(ENTRIES)) begin
                                ord_n[len_n[SW-1:0]] = r_fslot;
                                len_n = len_n + 1'b1;
                            end
                            r_live[r_fslot] <= 1'b1;
                            r_cnt[r_fslot] <= CW'(1);
                            if (r_hit) begin
                                r_live[r_hslot] <= 1'b0;
                                r_cnt[r_hslot] <= r_cnt[r_hslot] - 1'b1;
                                if (r_cnt[r_hslot] == CW'(1)) begin
                                    use_n = use_n - 1'b1;
                                end
                            end
                            r_ord <= ord_n;
                            r_olen <= len_n;
                            r_usage <= use_n;
                        end
                    end
                    OP_LOOKUP: begin
                        if (!r_hit) begin
                            r_rsp.status <= ST_MISS;
                        end else if (r_cnt[r_hslot] >= CW'(REF_MAX)) begin
                            r_rsp.status <= ST_LIMIT;
                        end else begin
                            logic [SW:0] p;
                            logic [SW-1:0] ord_n [ENTRIES];
                            ord_n = r_ord;
                            if (r_cnt[r_hslot] == CW'(1)) begin
                                p = ord_pos(r_hslot, ord_n, r_olen);
                                if (!p[SW]) begin
                                    for (int j = 0; j < ENTRIES - 1; j++) begin
                                        if (j >= int'(p[SW-1:0])) begin
                                            ord_n[j] = ord_n[j + 1];
                                        end
                                    end
                                    r_olen <= r_olen - 1'b1;
                                end
                            end
                            r_ord <= ord_n;
                            r_cnt[r_hslot] <= r_cnt[r_hslot] + 1'b1;
                            r_rsp.result_slot <= r_hslot;
                            r_rsp.result_value <= r_val[r_hslot];
                        end
                    end
                    OP_RELEASE: begin
                        logic [SW-1:0] s;
                        s = r_req.slot[SW-1:0];
                        if ((ENTRIES < 16 && r_req.slot >= 4'(ENTRIES)) ||
                            r_cnt[s] == '0 ||
                            (r_live[s] && r_cnt[s] == CW'(1))) begin
                            r_rsp.status <= ST_BAD;
                        end else begin
                            r_cnt[s] <= r_cnt[s] - 1'b1;
                            if (r_cnt[s] == CW'(1)) begin
                                r_live[s] <= 1'b0;
                                r_usage <= r_usage - 1'b1;
                            end else if (r_live[s] && r_cnt[s] == CW'(2)) begin
                                if (r_olen < NW'(ENTRIES)) begin
                                    r_ord[r_olen[SW-1:0]] <= s;
                                    r_olen <= r_olen + 1'b1;
                                end
                            end
                        end
                    end
                    default: begin
                        if (!r_hit) begin
                            r_rsp.status <= ST_MISS;
                        end else begin
                            logic [SW:0] p;
                            logic [SW-1:0] ord_n [ENTRIES];
                            ord_n = r_ord;
                            p = ord_pos(r_hslot, ord_n, r_olen);
                            if (!p[SW]) begin
                                for (int j = 0; j < ENTRIES - 1; j++) begin
                                    if (j >= int'(p[SW-1:0])) begin
                                        ord_n[j] = ord_n[j + 1];
                                    end
                                end
                                r_olen <= r_olen - 1'b1;
                            end
                            r_ord <= ord_n;
                            r_live[r_hslot] <= 1'b0;
                            r_cnt[r_hslot] <= r_cnt[r_hslot] - 1'b1;
                            if (r_cnt[r_hslot] == CW'(1)) begin
                                r_usage <= r_usage - 1'b1;
                            end
                        end
                    end
                endcase
            end
        end
    end

    `ASSERT_IMP(a_olen_le_usage, i_clk, i_rst_n, 1'b1, r_olen <= r_usage)
    `ASSERT_IMP(a_usage_bound, i_clk, i_rst_n, 1'b1, r_usage <= NW'(ENTRIES))
    `ASSERT_IMP(a_evict_has_head, i_clk, i_rst_n, i_cmd.evict, r_olen != '0)
endmodule

/* rtl/plc_ctrl.sv */
// Controller: sequences latch, eviction (inserts only), search and execute per request.
// Depends on plc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module plc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic [1:0]    i_op,
    input  plc_pkg::t_sts i_sts,
    output plc_pkg::t_cmd o_cmd,
    output logic          o_out_valid,
    input  logic          i_out_ready
);
    import plc_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EVICT  = 3'd1;
    localparam logic [2:0] S_SEARCH = 3'd2;
    localparam logic [2:0] S_EXEC   = 3'd3;
    localparam logic [2:0] S_OUT    = 3'd4;

    logic [2:0] r_state, n_state;
    logic       r_is_ins;
    logic       r_out_valid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state = (i_op == OP_INSERT) ? S_EVICT : S_SEARCH;
                end
            end
            S_EVICT: begin
                if (i_sts.need_evict) begin
                    o_cmd.evict = 1'b1;
                end else begin
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                o_cmd.search = 1'b1;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.execute = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_is_ins <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.latch) begin
                r_is_ins <= (i_op == OP_INSERT);
            end
            if (o_cmd.execute) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    `ASSERT_IMP(a_evict_insert, i_clk, i_rst_n, o_cmd.evict, r_is_ins)
    `ASSERT_NXT(a_exec_valid, i_clk, i_rst_n, o_cmd.execute, r_out_valid)
    `ASSERT_IMP(a_one_cmd, i_clk, i_rst_n, 1'b1, $onehot0(o_cmd))
endmodule
